@@ rtl/core/psrwb_pkg.sv @@
// ----------------------------------------------------------------------------
// psrwb_pkg: shared types and constants of the synthesizer word builder
// Holds limits, fixed register fields, status codes and queue entry types.
// ----------------------------------------------------------------------------
package psrwb_pkg;

    localparam int unsigned FRAC_MODULUS = 1000;
    localparam int unsigned BAND_CLK_DIV = 200;

    localparam logic [32:0] F_MIN = 33'd35000000;
    localparam logic [32:0] F_MAX = 33'd4400000000;

    localparam logic [2:0] CFG_REF   = 3'd0;
    localparam logic [2:0] CFG_POWER = 3'd1;
    localparam logic [2:0] CFG_OE    = 3'd2;
    localparam logic [2:0] CFG_LN    = 3'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_INTOV = 2'd2;

    // Synthesizer register indexes of the emitted words.
    localparam logic [2:0] WORD_R0 = 3'd0;
    localparam logic [2:0] WORD_R1 = 3'd1;
    localparam logic [2:0] WORD_R2 = 3'd2;
    localparam logic [2:0] WORD_R3 = 3'd3;
    localparam logic [2:0] WORD_R4 = 3'd4;
    localparam logic [2:0] WORD_R5 = 3'd5;

    // Classified request handed from the front part to the back part.
    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  div_log2;
        logic [32:0] vco;
    } job_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_FRAC,
        BK_EMIT
    } bk_state_t;

    // Divider choice from the output frequency thresholds.
    function automatic logic [2:0] pick_div(input logic [32:0] f);
        logic [2:0] d;
        begin
            if (f < 33'd68750000) d = 3'd6;
            else if (f < 33'd137500000) d = 3'd5;
            else if (f < 33'd275000000) d = 3'd4;
            else if (f < 33'd550000000) d = 3'd3;
            else if (f < 33'd1100000000) d = 3'd2;
            else if (f < 33'd2200000000) d = 3'd1;
            else d = 3'd0;
            return d;
        end
    endfunction

endpackage

@@ rtl/core/psrwb_front.sv @@
// ----------------------------------------------------------------------------
// psrwb_front: request classifier
// Range check, divider choice and VCO frequency; writes a job into the queue.
// ----------------------------------------------------------------------------
module psrwb_front
    import psrwb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [32:0] freq_hz,
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job
);

    job_t job_next;
    logic [2:0] d;

    // Classification is combinational; the queue registers it.
    always_comb
    begin
        d = pick_div(freq_hz);
        job_next.div_log2 = d;
        job_next.vco = freq_hz << d;
        if (freq_hz < F_MIN || freq_hz > F_MAX)
            job_next.status = ST_RANGE;
        else
            job_next.status = ST_OK;
    end

    // Two-entry queue between front and back.
    job_t       q_reg [2];
    logic [1:0] cnt_reg;
    logic       wp_reg, rp_reg;
    logic       push, pop;

    assign in_ready  = (cnt_reg != 2'd2);
    assign push      = in_valid && in_ready;
    assign job_valid = (cnt_reg != 2'd0);
    assign pop       = job_valid && job_ready;
    assign job       = q_reg[rp_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            if (push) wp_reg <= ~wp_reg;
            if (pop)  rp_reg <= ~rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) q_reg[wp_reg] <= job_next;
    end

endmodule

@@ rtl/core/psrwb_back.sv @@
// ----------------------------------------------------------------------------
// psrwb_back: divider and word emitter
// Restoring INT/FRAC division, then six words 5 to 0; an error emits one.
// ----------------------------------------------------------------------------
module psrwb_back
    import psrwb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    output logic        job_ready,
    input  job_t        job,
    input  logic [27:0] ref_freq_hz,
    input  logic [1:0]  power_level,
    input  logic        output_enable,
    input  logic        low_noise_mode,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] reg_word,
    output logic [2:0]  reg_index,
    output logic        last_word,
    output logic [1:0]  status
);

    bk_state_t   st_reg, st_next;
    logic [32:0] quo_reg, quo_next;
    logic [27:0] rem_reg, rem_next;
    logic [39:0] fnum_reg, fnum_next;
    logic [11:0] fq_reg, fq_next;
    logic [15:0] int_reg, int_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [2:0]  d_reg, d_next;
    logic [1:0]  st_code_reg, st_code_next;
    logic [2:0]  idx_reg, idx_next;
    logic [28:0] trial;
    logic [31:0] word;

    // Both divisions produce one quotient bit per cycle.
    always_comb
    begin
        st_next = st_reg; quo_next = quo_reg; rem_next = rem_reg; fq_next = fq_reg;
        fnum_next = fnum_reg; int_next = int_reg;
        cnt_next = cnt_reg; d_next = d_reg; st_code_next = st_code_reg;
        idx_next = idx_reg;
        job_ready = 1'b0; out_valid = 1'b0;
        trial = {rem_reg, quo_reg[32]};
        case (st_reg)
            BK_IDLE:
            begin
                job_ready = 1'b1;
                if (job_valid)
                begin
                    quo_next = job.vco; rem_next = '0; cnt_next = 6'd33;
                    d_next = job.div_log2; st_code_next = job.status;
                    idx_next = WORD_R5; fq_next = '0;
                    if (job.status != ST_OK) st_next = BK_EMIT;
                    else if (ref_freq_hz == 28'd0)
                    begin
                        st_code_next = ST_INTOV; st_next = BK_EMIT;
                    end
                    else st_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (trial >= {1'b0, ref_freq_hz})
                begin
                    rem_next = 28'(trial - {1'b0, ref_freq_hz});
                    quo_next = {quo_reg[31:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[27:0];
                    quo_next = {quo_reg[31:0], 1'b0};
                end
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    if (quo_next[32:16] != 17'd0)
                    begin
                        st_code_next = ST_INTOV; st_next = BK_EMIT;
                    end
                    else
                    begin
                        // The remainder times the modulus stays below 2^40.
                        int_next  = quo_next[15:0];
                        fnum_next = {12'd0, rem_next} * 40'(FRAC_MODULUS);
                        rem_next  = '0;
                        cnt_next  = 6'd40;
                        st_next   = BK_FRAC;
                    end
                end
            end
            BK_FRAC:
            begin
                trial = {rem_reg, fnum_reg[39]};
                if (trial >= {1'b0, ref_freq_hz})
                begin
                    rem_next = 28'(trial - {1'b0, ref_freq_hz});
                    fq_next  = {fq_reg[10:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[27:0];
                    fq_next  = {fq_reg[10:0], 1'b0};
                end
                fnum_next = {fnum_reg[38:0], 1'b0};
                cnt_next = cnt_reg - 6'd1;
                if (cnt_reg == 6'd1) st_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (idx_reg == WORD_R0 || st_code_reg != ST_OK) st_next = BK_IDLE;
                    else idx_next = idx_reg - 3'd1;
                end
            end
            default: st_next = BK_IDLE;
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= BK_IDLE; idx_reg <= WORD_R5;
            st_code_reg <= ST_OK; cnt_reg <= '0;
        end
        else
        begin
            st_reg <= st_next; idx_reg <= idx_next;
            st_code_reg <= st_code_next; cnt_reg <= cnt_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next; rem_reg <= rem_next; fnum_reg <= fnum_next;
        fq_reg <= fq_next; int_reg <= int_next; d_reg <= d_next;
    end

    // Word packing for the current index.
    always_comb
    begin
        case (idx_reg)
            WORD_R0: word = {1'b0, int_reg, fq_reg, 3'b000};
            WORD_R1: word = 32'((1 << 27) | (FRAC_MODULUS << 3) | 1);
            WORD_R2: word = (low_noise_mode ? 32'h0020_0000 : 32'h0010_0000)
                            | 32'h0000_4000 | 32'(6 << 9) | 32'd2;
            WORD_R3: word = 32'(3 << 10) | {27'd0, power_level, 3'b011};
            WORD_R4: word = {9'd0, d_reg, 20'd0} | 32'(BAND_CLK_DIV << 12)
                            | (output_enable ? 32'd0 : 32'h20) | 32'd4;
            WORD_R5: word = 32'((1 << 22) | 5);
            default: word = '0;
        endcase
    end

    assign reg_word  = (st_code_reg == ST_OK) ? word : 32'd0;
    assign reg_index = (st_code_reg == ST_OK) ? idx_reg : WORD_R0;
    assign last_word = (st_code_reg != ST_OK) || (idx_reg == WORD_R0);
    assign status    = st_code_reg;

endmodule

@@ rtl/core/pll_synth_register_word_builder.sv @@
// ----------------------------------------------------------------------------
// pll_synth_register_word_builder: fractional-N divider word builder
// Turns a requested output frequency into six synthesizer register words.
// ----------------------------------------------------------------------------
// Channel | Direction | Signals
// input   | in        | in_valid, in_ready, freq_hz
// output  | out       | out_valid, out_ready, reg_word, reg_index, last_word, status
// config  | in        | cfg_we, cfg_index, cfg_data
// An ok request takes the job, runs INT division and then FRAC division,
// both one bit per cycle, then makes six word transfers. A range error or
// zero reference goes straight to one transfer; an INT overflow ends INT
// division and makes one transfer. Output stalls hold the back part. A
// two-entry queue takes up to two requests while the back part works or
// stalls. Reset restores register defaults.
module pll_synth_register_word_builder
    import psrwb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [32:0] freq_hz,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] reg_word,
    output logic [2:0]  reg_index,
    output logic        last_word,
    output logic [1:0]  status,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [27:0] cfg_data
);

    logic [27:0] ref_reg;
    logic [1:0]  pwr_reg;
    logic        oe_reg, ln_reg;
    logic        job_valid, job_ready;
    job_t        job;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg <= 28'd25000000; pwr_reg <= 2'd3; oe_reg <= 1'b1; ln_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_REF:   ref_reg <= cfg_data;
                CFG_POWER: pwr_reg <= cfg_data[1:0];
                CFG_OE:    oe_reg  <= cfg_data[0];
                CFG_LN:    ln_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    psrwb_front u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .freq_hz(freq_hz), .job_valid(job_valid), .job_ready(job_ready), .job(job)
    );

    psrwb_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job_ready(job_ready),
        .job(job), .ref_freq_hz(ref_reg), .power_level(pwr_reg),
        .output_enable(oe_reg), .low_noise_mode(ln_reg), .out_valid(out_valid),
        .out_ready(out_ready), .reg_word(reg_word), .reg_index(reg_index),
        .last_word(last_word), .status(status)
    );

endmodule

@@ rtl/core/psrwb_checker.sv @@
// ----------------------------------------------------------------------------
// psrwb_props: port-level checks of the word builder
// Watches the result channel for consistent framing.
// ----------------------------------------------------------------------------
module psrwb_props
    import psrwb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] reg_word,
    input logic [2:0]  reg_index,
    input logic        last_word,
    input logic [1:0]  status
);

    // An error transfer carries a zero word at index zero and ends the request.
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != ST_OK |-> reg_word == 32'd0 && last_word && reg_index == 3'd0)
        else $error("error transfer malformed");

    // The last flag of an ok request sits on index zero only.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == ST_OK |-> last_word == (reg_index == 3'd0))
        else $error("last flag misplaced");

    // Ok words step down by one index.
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && status == ST_OK && !last_word ##1 out_valid
        |-> reg_index == $past(reg_index) - 3'd1)
        else $error("index sequence broken");

    // A stalled result holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(reg_word))
        else $error("stalled result changed");

endmodule

bind pll_synth_register_word_builder psrwb_props u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_ready(out_ready),
    .reg_word(reg_word), .reg_index(reg_index), .last_word(last_word), .status(status)
);

@@ tb/psrwb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psrwb_checker: word prediction and comparison for the word builder
// Watches the request and word channels, works out the register words for
// each accepted request and compares every word transfer against them.
// ----------------------------------------------------------------------------
module psrwb_checker
    import psrwb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [32:0] freq_hz,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] reg_word,
    input  logic [2:0]  reg_index,
    input  logic        last_word,
    input  logic [1:0]  status,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [27:0] cfg_data,
    output int          fail_count,
    output int          words_pending
);

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
        logic [1:0]  st;
    } word_t;

    word_t       word_queue[$];
    logic [27:0] ref_hz;
    logic [1:0]  pwr;
    logic        oe;
    logic        ln;

    assign words_pending = word_queue.size();

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $time);
        fail_count++;
    endtask

    function automatic word_t err_word(input logic [1:0] code);
        word_t w;
        w.word = '0;
        w.idx  = '0;
        w.last = 1'b1;
        w.st   = code;
        return w;
    endfunction

    // Work out the words of one request and queue them.
    task automatic predict_words(input logic [32:0] f);
        logic [2:0]  d;
        logic [63:0] vco, iv, rem, frac;
        logic [31:0] w[6];
        word_t       e;
        begin
            if (f < F_MIN || f > F_MAX)
            begin
                word_queue.push_back(err_word(ST_RANGE));
                return;
            end
            if (f < 33'd68750000) d = 3'd6;
            else if (f < 33'd137500000) d = 3'd5;
            else if (f < 33'd275000000) d = 3'd4;
            else if (f < 33'd550000000) d = 3'd3;
            else if (f < 33'd1100000000) d = 3'd2;
            else if (f < 33'd2200000000) d = 3'd1;
            else d = 3'd0;
            vco = 64'(f) << d;
            if (ref_hz == 0)
            begin
                word_queue.push_back(err_word(ST_INTOV));
                return;
            end
            iv = vco / 64'(ref_hz);
            if (iv > 65535)
            begin
                word_queue.push_back(err_word(ST_INTOV));
                return;
            end
            rem  = vco % 64'(ref_hz);
            frac = (rem * FRAC_MODULUS) / 64'(ref_hz);
            w[0] = 32'((iv << 15) | ((frac & 64'hFFF) << 3));
            w[1] = (32'd1 << 27) | (32'(FRAC_MODULUS) << 3) | 32'd1;
            w[2] = (ln ? (32'd1 << 21) : (32'd1 << 20)) | (32'd1 << 14) | (32'd6 << 9) | 32'd2;
            w[3] = (32'd3 << 10) | (32'(pwr) << 3) | 32'd3;
            w[4] = (32'(d) << 20) | (32'(BAND_CLK_DIV) << 12) | (oe ? 32'd0 : 32'd32) | 32'd4;
            w[5] = (32'd1 << 22) | 32'd5;
            for (int k = 5; k >= 0; k--)
            begin
                e.word = w[k];
                e.idx  = 3'(k);
                e.last = (k == 0);
                e.st   = ST_OK;
                word_queue.push_back(e);
            end
        end
    endtask

    // Track configuration, predict on request transfers, check word transfers.
    always @(posedge clk or negedge rst_n)
    begin
        word_t e;
        if (!rst_n)
        begin
            ref_hz = 28'd25000000;
            pwr    = 2'd3;
            oe     = 1'b1;
            ln     = 1'b1;
            word_queue.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_REF:   ref_hz = cfg_data;
                    CFG_POWER: pwr = cfg_data[1:0];
                    CFG_OE:    oe = cfg_data[0];
                    CFG_LN:    ln = cfg_data[0];
                    default:   ;
                endcase
            end
            if (in_valid && in_ready)
                predict_words(freq_hz);
            if (out_valid && out_ready)
            begin
                if (word_queue.size() == 0)
                    report("unexpected word", reg_word, 0);
                else
                begin
                    e = word_queue.pop_front();
                    if (reg_word !== e.word) report("reg_word", reg_word, e.word);
                    if (reg_index !== e.idx) report("reg_index", 32'(reg_index), 32'(e.idx));
                    if (last_word !== e.last) report("last_word", 32'(last_word), 32'(e.last));
                    if (status !== e.st) report("status", 32'(status), 32'(e.st));
                end
            end
        end
    end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the synthesizer word builder
// Sends directed and random frequency requests across several register
// settings with random gaps and stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
    import psrwb_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [32:0] freq_hz;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] reg_word;
    logic [2:0]  reg_index;
    logic        last_word;
    logic [1:0]  status;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [27:0] cfg_data;
    int          fail_count;
    int          words_pending;
    int          cycle_count;

    pll_synth_register_word_builder DUT (.*);
    psrwb_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Run limit for about 320 requests, with stalls.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Receiver stalls at random; some stretches never stall.
    int stall_mode;
    always @(posedge clk)
    begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        if (stall_mode == 0) out_ready <= 1'b1;
        else if (stall_mode == 1) out_ready <= ($urandom_range(0, 3) != 0);
        else out_ready <= ($urandom_range(0, 9) < 2);
    end

    // Valid stays high into the next request when there is no gap.
    task automatic send_request(input logic [32:0] f);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid <= 1'b1;
        freq_hz  <= f;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Write a register once every expected word has arrived.
    task automatic write_reg(input logic [2:0] idx, input logic [27:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [32:0] rand_freq();
        int r;
        r = $urandom_range(0, 99);
        if (r < 8) return 33'($urandom_range(0, 34999999));
        if (r < 14) return {1'b1, 32'($urandom)};
        if (r < 18) return 33'd4400000001 + 33'($urandom_range(0, 100000000));
        return 33'(64'd35000000 + ((64'($urandom) * 64'd4365000001) >> 32));
    endfunction

    initial
    begin
        logic [32:0] dir[$];
        logic [27:0] refs[6];
        in_valid    = 1'b0;
        freq_hz     = '0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        out_ready   = 1'b0;
        stall_mode  = 0;
        cycle_count = 0;
        rst_n       = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: range edges, every divider threshold, field extremes.
        dir = '{33'd0, 33'd34999999, 33'd35000000, 33'd68749999, 33'd68750000,
                33'd137499999, 33'd137500000, 33'd274999999, 33'd275000000,
                33'd549999999, 33'd550000000, 33'd1099999999, 33'd1100000000,
                33'd2199999999, 33'd2200000000, 33'd4400000000, 33'd4400000001,
                33'h1FFFFFFFF, 33'd1234567891};
        foreach (dir[i]) send_request(dir[i]);
        // Tiny reference forces INT overflow; zero reference too.
        write_reg(CFG_REF, 28'd1);
        send_request(33'd100000000);
        write_reg(CFG_REF, 28'd0);
        send_request(33'd100000000);
        write_reg(3'd6, 28'hFFFFFFF);
        send_request(33'd3000000000);

        // Random phases across register settings, extremes included.
        refs = '{28'd25000000, 28'hFFFFFFF, 28'd250000000, 28'd70000, 28'd10000000,
                 28'd0};
        for (int p = 0; p < 6; p++)
        begin
            write_reg(CFG_REF, (p == 5) ? 28'($urandom_range(1000000, 250000000)) : refs[p]);
            write_reg(CFG_POWER, 28'(p % 4));
            write_reg(CFG_OE, 28'(p % 2));
            write_reg(CFG_LN, 28'((p / 2) % 2));
            write_reg(3'($urandom_range(4, 7)), 28'($urandom));
            for (int i = 0; i < 50; i++) send_request(rand_freq());
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0) @(posedge clk);
        repeat (150) @(posedge clk);
        if (fail_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
